>>> rtl/core/bds_pkg.sv
// Shared types, constants and saturation helper for the Burgers stencil step.
// Used by every module under rtl/core; depends on nothing.
package bds_pkg;

  localparam int Q_W     = 32;
  localparam int FRAC_W  = 16;
  localparam int IDX_W   = 10;
  localparam int OPD_W   = Q_W + 1;
  localparam int PROD_W  = 2 * OPD_W;
  localparam int WIDE_W  = PROD_W - FRAC_W;

  localparam int MAX_POINTS_DEF = 1024;

  localparam logic [Q_W-1:0] CONV_RESET = 32'd4588;
  localparam logic [Q_W-1:0] DIFF_RESET = 32'd321;

  typedef enum logic [0:0] {
    REG_CONVECTION = 1'b0,
    REG_DIFFUSION  = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic                    issue;
    logic signed [OPD_W-1:0] a;
    logic signed [OPD_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic                  req;
    logic signed [Q_W-1:0] value;
    logic [IDX_W-1:0]      index;
    logic                  last;
    logic                  short_line;
  } emit_t;

  function automatic logic signed [Q_W-1:0] sat_q(input logic signed [WIDE_W-1:0] x);
    logic signed [WIDE_W-1:0] hi;
    logic signed [WIDE_W-1:0] lo;
    hi = {{(WIDE_W-Q_W+1){1'b0}}, {(Q_W-1){1'b1}}};
    lo = ~hi;
    if (x > hi) begin
      sat_q = hi[Q_W-1:0];
    end else if (x < lo) begin
      sat_q = lo[Q_W-1:0];
    end else begin
      sat_q = x[Q_W-1:0];
    end
  endfunction

endpackage

>>> rtl/core/bds_mul_unit.sv
// Shared multiplier: registered product, then registered round-half-up and saturation to Q16.16.
// Depends on bds_pkg.
module bds_mul_unit (
  input  logic                              clk,
  input  bds_pkg::mul_req_t                 req,
  output logic signed [bds_pkg::Q_W-1:0]    res
);
  import bds_pkg::*;

  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] rnd;
  logic signed [PROD_W-1:0] shifted;

  always_comb begin
    rnd     = prod + $signed({{(PROD_W-FRAC_W){1'b0}}, 1'b1, {(FRAC_W-1){1'b0}}});
    shifted = rnd >>> FRAC_W;
  end

  always_ff @(posedge clk) begin
    if (req.issue) begin
      prod <= req.a * req.b;
    end
    res <= sat_q($signed(shifted[WIDE_W-1:0]));
  end

endmodule

>>> rtl/core/bds_seq.sv
// Sequencer for one grid point update: window state, operand selection and final sum.
// Depends on bds_pkg; drives the shared bds_mul_unit.
module bds_seq #(
  parameter int MAX_POINTS = bds_pkg::MAX_POINTS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             src_valid,
  input  logic signed [bds_pkg::Q_W-1:0]   sample,
  input  logic                             last_sample,
  input  logic [bds_pkg::Q_W-1:0]          conv_coeff,
  input  logic [bds_pkg::Q_W-1:0]          diff_coeff,
  input  logic                             out_free,
  output logic                             busy,
  output bds_pkg::emit_t                   emit
);
  import bds_pkg::*;

  localparam int PW = $clog2(MAX_POINTS);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_PREP  = 10'b0000000010,
    S_MUL1  = 10'b0000000100,
    S_WAIT1 = 10'b0000001000,
    S_MUL2  = 10'b0000010000,
    S_MUL3  = 10'b0000100000,
    S_WAIT3 = 10'b0001000000,
    S_SUM   = 10'b0010000000,
    S_EMIT  = 10'b0100000000,
    S_WRAP  = 10'b1000000000
  } state_t;

  state_t                state;
  logic [PW-1:0]         pos;
  logic signed [Q_W-1:0] wp;
  logic signed [Q_W-1:0] wp2;
  logic signed [Q_W-1:0] sp;
  logic                  job;
  logic                  last_r;
  logic                  short_r;

  logic signed [Q_W-1:0] samp_r;
  logic signed [Q_W-1:0] d_r;
  logic signed [Q_W-1:0] lap_r;
  logic signed [Q_W-1:0] tc_r;
  logic signed [Q_W-1:0] val_r;

  logic signed [Q_W-1:0] um_sel;
  logic signed [Q_W-1:0] u_sel;
  logic signed [Q_W-1:0] up_sel;
  logic signed [Q_W-1:0] mul_res;
  mul_req_t              mreq;
  logic                  accept;
  logic                  last_eff;
  logic                  pos_lt2;
  logic [PW-1:0]         idx_pos;
  logic [PW+IDX_W-1:0]   idx_ext;

  assign busy     = (state != S_IDLE);
  assign accept   = src_valid && (state == S_IDLE);
  assign last_eff = last_sample || (pos == PW'(MAX_POINTS - 1));
  assign pos_lt2  = (pos < PW'(2));

  assign um_sel = job ? wp     : wp2;
  assign u_sel  = job ? samp_r : wp;
  assign up_sel = job ? sp     : samp_r;

  always_comb begin
    mreq.issue = 1'b0;
    mreq.a     = OPD_W'(u_sel);
    mreq.b     = OPD_W'(d_r);
    unique case (state)
      S_MUL1: begin
        mreq.issue = 1'b1;
      end
      S_MUL2: begin
        mreq.issue = 1'b1;
        mreq.a     = OPD_W'(mul_res);
        mreq.b     = $signed({1'b0, conv_coeff});
      end
      S_MUL3: begin
        mreq.issue = 1'b1;
        mreq.a     = OPD_W'(lap_r);
        mreq.b     = $signed({1'b0, diff_coeff});
      end
      default: begin
        mreq.issue = 1'b0;
      end
    endcase
  end

  bds_mul_unit u_mul (
    .clk (clk),
    .req (mreq),
    .res (mul_res)
  );

  always_comb begin
    idx_pos = job ? pos : pos - PW'(1);
    idx_ext = {{IDX_W{1'b0}}, idx_pos};
    emit.req        = (state == S_EMIT) || (state == S_WRAP);
    emit.value      = val_r;
    emit.index      = (state == S_WRAP) ? '0 : idx_ext[IDX_W-1:0];
    emit.last       = (state == S_WRAP);
    emit.short_line = (state == S_WRAP) && short_r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      pos     <= '0;
      wp      <= '0;
      wp2     <= '0;
      sp      <= '0;
      job     <= 1'b0;
      last_r  <= 1'b0;
      short_r <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (last_eff && pos_lt2) begin
              short_r <= 1'b1;
              wp      <= '0;
              wp2     <= '0;
              sp      <= '0;
              pos     <= '0;
              state   <= S_WRAP;
            end else if (!pos_lt2) begin
              short_r <= 1'b0;
              last_r  <= last_eff;
              job     <= 1'b0;
              state   <= S_PREP;
            end else begin
              if (pos == PW'(1)) begin
                sp <= sample;
              end
              wp2 <= wp;
              wp  <= sample;
              pos <= pos + PW'(1);
            end
          end
        end
        S_PREP:  state <= S_MUL1;
        S_MUL1:  state <= S_WAIT1;
        S_WAIT1: state <= S_MUL2;
        S_MUL2:  state <= S_MUL3;
        S_MUL3:  state <= S_WAIT3;
        S_WAIT3: state <= S_SUM;
        S_SUM:   state <= S_EMIT;
        S_EMIT: begin
          if (out_free) begin
            if (job) begin
              state <= S_WRAP;
            end else if (last_r) begin
              job   <= 1'b1;
              state <= S_PREP;
            end else begin
              wp2   <= wp;
              wp    <= samp_r;
              pos   <= pos + PW'(1);
              state <= S_IDLE;
            end
          end
        end
        S_WRAP: begin
          if (out_free) begin
            wp    <= '0;
            wp2   <= '0;
            sp    <= '0;
            pos   <= '0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      samp_r <= sample;
      val_r  <= '0;
    end
    if (state == S_PREP) begin
      d_r   <= sat_q(WIDE_W'(u_sel) - WIDE_W'(um_sel));
      lap_r <= sat_q(WIDE_W'(up_sel) + WIDE_W'(um_sel) - (WIDE_W'(u_sel) <<< 1));
    end
    if (state == S_WAIT3) begin
      tc_r <= mul_res;
    end
    if (state == S_SUM) begin
      val_r <= sat_q(WIDE_W'(u_sel) - WIDE_W'(tc_r) + WIDE_W'(mul_res));
    end
  end

  a_pos_step: assert property (@(posedge clk) disable iff (rst)
    (pos == $past(pos)) || (pos == $past(pos) + PW'(1)) || (pos == '0))
    else $error("position moved by more than one point");

  a_window_hold: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) && $past(state != S_IDLE) |-> $stable(wp) && $stable(wp2) && $stable(sp))
    else $error("window changed during a point update");

  a_short_clean: assert property (@(posedge clk) disable iff (rst)
    (state == S_WRAP) && short_r |-> (val_r == '0))
    else $error("short line result carries data");

endmodule

>>> rtl/core/burgers_1d_stencil_step_top.sv
// Top level of the 1-D Burgers stencil step: config registers, output register, sequencer.
// Depends on bds_pkg, bds_seq and bds_mul_unit.
//
//   channel   signals                                            flow
//   src       src_valid, src_stall, sample, last_sample          in, one grid point
//   res       res_valid, res_stall, new_value, point_index,      out, one updated point
//             last_result, too_short
//   cfg       cfg_valid, cfg_ready, cfg_index, cfg_data          in, register write
//
// A point that yields no result only shifts the window; an interior point runs one update,
// and a last point two, set by the shared multiplier (three products per update, each
// with a registered product and a registered rounding; the second waits on the first).
// A short line yields one marked result. Reset is synchronous and clears window and position.
// res_stall holds the sequencer at its emit step; src_stall is high while a point is at work.
module burgers_1d_stencil_step_top #(
  parameter int MAX_POINTS = bds_pkg::MAX_POINTS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             src_valid,
  output logic                             src_stall,
  input  logic signed [bds_pkg::Q_W-1:0]   sample,
  input  logic                             last_sample,
  output logic                             res_valid,
  input  logic                             res_stall,
  output logic signed [bds_pkg::Q_W-1:0]   new_value,
  output logic [bds_pkg::IDX_W-1:0]        point_index,
  output logic                             last_result,
  output logic                             too_short,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  bds_pkg::cfg_reg_t                cfg_index,
  input  logic [bds_pkg::Q_W-1:0]          cfg_data
);
  import bds_pkg::*;

  logic [Q_W-1:0] conv_coeff;
  logic [Q_W-1:0] diff_coeff;
  logic           busy;
  logic           out_free;
  emit_t          emit;

  assign cfg_ready = 1'b1;
  assign src_stall = busy;
  assign out_free  = !res_valid || !res_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      conv_coeff <= CONV_RESET;
      diff_coeff <= DIFF_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_CONVECTION: conv_coeff <= cfg_data;
        REG_DIFFUSION:  diff_coeff <= cfg_data;
        default:        conv_coeff <= conv_coeff;
      endcase
    end
  end

  bds_seq #(
    .MAX_POINTS (MAX_POINTS)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .src_valid   (src_valid),
    .sample      (sample),
    .last_sample (last_sample),
    .conv_coeff  (conv_coeff),
    .diff_coeff  (diff_coeff),
    .out_free    (out_free),
    .busy        (busy),
    .emit        (emit)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_free) begin
      res_valid <= emit.req;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && emit.req) begin
      new_value   <= emit.value;
      point_index <= emit.index;
      last_result <= emit.last;
      too_short   <= emit.short_line;
    end
  end

  a_short_fields: assert property (@(posedge clk) disable iff (rst)
    res_valid && too_short |-> last_result && (point_index == '0) && (new_value == '0))
    else $error("short line result with unexpected fields");

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(new_value) && $stable(point_index) &&
      $stable(last_result) && $stable(too_short))
    else $error("stalled result transaction changed");

  a_last_index: assert property (@(posedge clk) disable iff (rst)
    res_valid && last_result |-> (point_index == '0))
    else $error("final result of a line not at point zero");

endmodule
